// ===== src/rrts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

  // Sizes of the task table and of each task's stack frame.
  localparam int MAX_TASKS_DEFAULT  = 4;
  localparam int STACK_BYTES        = 256;
  localparam int CONTEXT_BYTES      = 35;
  localparam int RETURN_FRAME_BYTES = 4;
  localparam int ADDR_W             = 16;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [1:0]        task_id_t;
  typedef logic [1:0]        cmd_t;
  typedef logic [2:0]        status_t;
  typedef logic [1:0]        slot_state_t;

  // Command codes.
  localparam cmd_t CMD_CREATE    = 2'd0;
  localparam cmd_t CMD_YIELD     = 2'd1;
  localparam cmd_t CMD_TERMINATE = 2'd2;
  localparam cmd_t CMD_START     = 2'd3;

  // Status codes.
  localparam status_t STAT_OK       = 3'd0;
  localparam status_t STAT_FULL     = 3'd1;
  localparam status_t STAT_NO_READY = 3'd2;
  localparam status_t STAT_IGNORED  = 3'd3;
  localparam status_t STAT_CREATED  = 3'd4;

  // Slot states.
  localparam slot_state_t SLOT_DEAD    = 2'd0;
  localparam slot_state_t SLOT_READY   = 2'd1;
  localparam slot_state_t SLOT_RUNNING = 2'd2;

  // Command transaction.
  typedef struct packed {
    cmd_t  command;
    addr_t entry_address;
    addr_t saved_stack_pointer;
  } request_t;

  // Result transaction.
  typedef struct packed {
    task_id_t running_task;
    addr_t    resume_stack_pointer;
    task_id_t created_slot;
    status_t  status;
  } result_t;

  // Update of one slot state entry.
  typedef struct packed {
    logic        en;
    slot_state_t state;
  } slot_wr_t;

endpackage

`default_nettype wire

// ===== src/rrts_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/rrts_slot_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrts_slot_table #(
  parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [$clog2(MAX_TASKS)-1:0] rd_idx,
  output rrts_pkg::slot_state_t             rd_state,
  input  wire logic [$clog2(MAX_TASKS)-1:0] wr_idx,
  input  wire rrts_pkg::slot_wr_t           wr
);

  rrts_pkg::slot_state_t slot_state [MAX_TASKS];

  // Per-slot state flops; every slot is dead after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        slot_state[i] <= rrts_pkg::SLOT_DEAD;
      end
    end else if (wr.en) begin
      slot_state[wr_idx] <= wr.state;
    end
  end

  // The sequencer looks at one slot per cycle.
  assign rd_state = slot_state[rd_idx];

endmodule

`default_nettype wire

// ===== src/round_robin_task_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel    Ports                          Transaction
// command    start, busy, request           taken when start is high and busy is low
// result     done, result                   valid for the one cycle that done is high
// config     cfg_write, cfg_data            stack region base, written when cfg_write is high
//
// A multi-cycle command holds busy high from the cycle after it is accepted until the cycle
// its result is strobed. Create examines the slots in order from slot 0 for a dead entry.
// Yield, terminate and start scan the slots round-robin for a ready entry, then, if one is
// found, read the stack pointer memory. Start while running only reads the memory; other
// ignored commands and a full table answer without raising busy. Reset is synchronous and
// empties the table. The receiver cannot stall; done is a pulse.

module round_robin_task_scheduler #(
  parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire rrts_pkg::request_t request,
  output logic                    done,
  output rrts_pkg::result_t       result,
  input  wire logic               cfg_write,
  input  wire rrts_pkg::addr_t    cfg_data
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TASKS);
  localparam rrts_pkg::addr_t STACK_STEP = rrts_pkg::addr_t'(rrts_pkg::STACK_BYTES);
  localparam rrts_pkg::addr_t FRAME_OFFSET = rrts_pkg::addr_t'(
    rrts_pkg::STACK_BYTES - 1 - rrts_pkg::RETURN_FRAME_BYTES - rrts_pkg::CONTEXT_BYTES);

  // Sequencer states.
  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_FIND_DEAD  = 3'd1;
  localparam logic [2:0] S_FIND_READY = 3'd2;
  localparam logic [2:0] S_READ       = 3'd3;
  localparam logic [2:0] S_REPLY      = 3'd4;

  logic [2:0]                 state;
  logic [IDX_W-1:0]           idx;
  logic [IDX_W-1:0]           steps;
  logic [IDX_W-1:0]           cur;
  logic [IDX_W-1:0]           search;
  logic [CNT_W-1:0]           live;
  logic                       running;
  rrts_pkg::addr_t            ptr;
  rrts_pkg::addr_t            base;
  rrts_pkg::addr_t            sp_saved;
  rrts_pkg::status_t          status_r;

  logic                       accept;
  logic [IDX_W-1:0]           idx_inc;
  rrts_pkg::slot_state_t      scan_state;
  logic [IDX_W-1:0]           slot_wr_idx;
  rrts_pkg::slot_wr_t         slot_wr;
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  rrts_pkg::addr_t            ram_wdata;
  rrts_pkg::addr_t            ram_rdata;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign idx_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;

  rrts_slot_table #(
    .MAX_TASKS (MAX_TASKS)
  ) u_slots (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (idx),
    .rd_state (scan_state),
    .wr_idx   (slot_wr_idx),
    .wr       (slot_wr)
  );

  // Saved stack pointers; the read side always follows the running slot.
  rrts_ram #(
    .WIDTH (rrts_pkg::ADDR_W),
    .DEPTH (MAX_TASKS)
  ) u_sp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur),
    .rdata (ram_rdata)
  );

  // Table writes: the caller's pointer and state on acceptance, then scan hits.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = cur;
    ram_wdata   = request.saved_stack_pointer;
    slot_wr_idx = cur;
    slot_wr     = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (request.command) inside
            rrts_pkg::CMD_CREATE: begin
              ram_we = running;
            end
            rrts_pkg::CMD_YIELD, rrts_pkg::CMD_TERMINATE: begin
              if (running) begin
                ram_we        = 1'b1;
                slot_wr.en    = 1'b1;
                slot_wr.state = (request.command == rrts_pkg::CMD_YIELD) ?
                                rrts_pkg::SLOT_READY : rrts_pkg::SLOT_DEAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FIND_DEAD: begin
        if (scan_state == rrts_pkg::SLOT_DEAD) begin
          ram_we        = 1'b1;
          ram_waddr     = idx;
          ram_wdata     = ptr;
          slot_wr_idx   = idx;
          slot_wr.en    = 1'b1;
          slot_wr.state = rrts_pkg::SLOT_READY;
        end
      end
      S_FIND_READY: begin
        if (scan_state == rrts_pkg::SLOT_READY) begin
          slot_wr_idx   = idx;
          slot_wr.en    = 1'b1;
          slot_wr.state = rrts_pkg::SLOT_RUNNING;
        end
      end
      S_READ, S_REPLY: begin
      end
      default: begin
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= rrts_pkg::addr_t'(512);
    end else if (cfg_write) begin
      base <= cfg_data;
    end
  end

  // Sequencer: one slot per cycle through the shared slot-state read and the pointer adder.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      idx     <= '0;
      steps   <= '0;
      cur     <= '0;
      search  <= '0;
      live    <= '0;
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            sp_saved <= request.saved_stack_pointer;
            result.created_slot <= '0;
            case (request.command) inside
              rrts_pkg::CMD_CREATE: begin
                if (live >= FULL_CNT) begin
                  result.running_task         <= running ? rrts_pkg::task_id_t'(cur) : '0;
                  result.resume_stack_pointer <= running ? request.saved_stack_pointer : '0;
                  result.status               <= rrts_pkg::STAT_FULL;
                  done                        <= 1'b1;
                end else begin
                  idx   <= '0;
                  ptr   <= base + FRAME_OFFSET;
                  state <= S_FIND_DEAD;
                end
              end
              rrts_pkg::CMD_YIELD, rrts_pkg::CMD_TERMINATE: begin
                if (!running) begin
                  result.running_task         <= '0;
                  result.resume_stack_pointer <= '0;
                  result.status               <= rrts_pkg::STAT_IGNORED;
                  done                        <= 1'b1;
                end else begin
                  if (request.command == rrts_pkg::CMD_TERMINATE && live != '0) begin
                    live <= live - 1'b1;
                  end
                  idx   <= search;
                  steps <= '0;
                  state <= S_FIND_READY;
                end
              end
              default: begin
                if (running) begin
                  status_r <= rrts_pkg::STAT_IGNORED;
                  state    <= S_READ;
                end else if (live == '0) begin
                  result.running_task         <= '0;
                  result.resume_stack_pointer <= '0;
                  result.status               <= rrts_pkg::STAT_IGNORED;
                  done                        <= 1'b1;
                end else begin
                  idx   <= search;
                  steps <= '0;
                  state <= S_FIND_READY;
                end
              end
            endcase
          end
        end
        S_FIND_DEAD: begin
          if (scan_state == rrts_pkg::SLOT_DEAD) begin
            live                        <= live + 1'b1;
            result.created_slot         <= rrts_pkg::task_id_t'(idx);
            result.running_task         <= running ? rrts_pkg::task_id_t'(cur) : '0;
            result.resume_stack_pointer <= running ? sp_saved : '0;
            result.status               <= rrts_pkg::STAT_CREATED;
            done                        <= 1'b1;
            state                       <= S_IDLE;
          end else if (idx == LAST_IDX) begin
            result.running_task         <= running ? rrts_pkg::task_id_t'(cur) : '0;
            result.resume_stack_pointer <= running ? sp_saved : '0;
            result.status               <= rrts_pkg::STAT_FULL;
            done                        <= 1'b1;
            state                       <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
            ptr <= ptr + STACK_STEP;
          end
        end
        S_FIND_READY: begin
          if (scan_state == rrts_pkg::SLOT_READY) begin
            cur      <= idx;
            search   <= idx_inc;
            running  <= 1'b1;
            status_r <= rrts_pkg::STAT_OK;
            state    <= S_READ;
          end else if (steps == LAST_IDX) begin
            // Nothing left to run: the scheduler stops.
            running                     <= 1'b0;
            result.running_task         <= '0;
            result.resume_stack_pointer <= '0;
            result.status               <= rrts_pkg::STAT_NO_READY;
            done                        <= 1'b1;
            state                       <= S_IDLE;
          end else begin
            idx   <= idx_inc;
            steps <= steps + 1'b1;
          end
        end
        S_READ: begin
          // The memory read of the running slot's pointer is under way.
          state <= S_REPLY;
        end
        S_REPLY: begin
          result.running_task         <= rrts_pkg::task_id_t'(cur);
          result.resume_stack_pointer <= ram_rdata;
          result.status               <= status_r;
          done                        <= 1'b1;
          state                       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
